FILE: rtl/rmmm_pkg.sv
// Shared types and constants for the running min/max/mean summary block.
// Used by the controller, the datapath and the top level; depends on nothing.

package rmmm_pkg;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } rmmm_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_sample;  // fold a non-negative reading into the run
    logic start_div;    // snapshot the run, start the mean division, clear the run
    logic div_step;     // one restoring-division step
    logic load_out;     // move the finished summary into the output register
  } rmmm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sample_neg;   // current input reading is an end marker
  } rmmm_stat_t;

  // Bit positions of the result flags in the output tuser.
  localparam int unsigned TUSER_EMPTY = 0;
  localparam int unsigned TUSER_OVF   = 1;
  localparam int unsigned TUSER_W     = 2;

endpackage

FILE: rtl/rmmm_ctrl.sv
// Controller state machine for the running min/max/mean summary block.
// Depends on rmmm_pkg for the state enum and the command/status structs.

module rmmm_ctrl
  import rmmm_pkg::*;
#(
  parameter int MAG_W = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  rmmm_stat_t stat_i,
  output rmmm_cmd_t  cmd_o
);

  localparam int STEP_W = $clog2(MAG_W);

  rmmm_state_e      state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              last_step;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_step = (step_q == STEP_W'(MAG_W - 1));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && stat_i.sample_neg) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_step) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output and command decode.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.take_sample = in_valid_i && !stat_i.sample_neg;
        cmd_o.start_div   = in_valid_i && stat_i.sample_neg;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_LOAD: begin
        cmd_o.load_out = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Division step counter; it restarts with each end marker.
  always_comb begin
    step_d = step_q;
    if (cmd_o.start_div) begin
      step_d = '0;
    end else if (cmd_o.div_step) begin
      step_d = step_q + STEP_W'(1);
    end
  end

  // The output register holds its request until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/rmmm_datapath.sv
// Datapath for the running min/max/mean summary block: run statistics,
// a restoring divider for the mean, and the output register.
// Depends on rmmm_pkg for the command/status structs.

module rmmm_datapath
  import rmmm_pkg::*;
#(
  parameter int COUNT_WIDTH  = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rmmm_cmd_t               cmd_i,
  output rmmm_stat_t              stat_o,
  input  logic [SAMPLE_WIDTH-1:0] reading_i,
  output logic [COUNT_WIDTH-1:0]  sample_count_o,
  output logic [SAMPLE_WIDTH-2:0] min_value_o,
  output logic [SAMPLE_WIDTH-2:0] max_value_o,
  output logic [SAMPLE_WIDTH-2:0] mean_value_o,
  output logic                    empty_run_o,
  output logic                    count_overflow_o
);

  localparam int MAG_W = SAMPLE_WIDTH - 1;
  localparam int SUM_W = MAG_W + COUNT_WIDTH;

  logic [MAG_W-1:0]       sample;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [MAG_W-1:0]       min_q, min_d;
  logic [MAG_W-1:0]       max_q, max_d;
  logic                   drop_q, drop_d;

  logic [COUNT_WIDTH-1:0] rem_q, den_q;
  logic [MAG_W-1:0]       quo_q;
  logic [COUNT_WIDTH:0]   trial;
  logic                   fits;

  logic [COUNT_WIDTH-1:0] snap_count_q;
  logic [MAG_W-1:0]       snap_min_q, snap_max_q;
  logic                   snap_drop_q, snap_empty_q;

  assign sample            = reading_i[MAG_W-1:0];
  assign stat_o.sample_neg = reading_i[SAMPLE_WIDTH-1];

  // Run statistics update; a full count drops the sample and flags it.
  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    min_d   = min_q;
    max_d   = max_q;
    drop_d  = drop_q;
    if (cmd_i.start_div) begin
      count_d = '0;
      sum_d   = '0;
      min_d   = '1;
      max_d   = '0;
      drop_d  = 1'b0;
    end else if (cmd_i.take_sample) begin
      if (&count_q) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + COUNT_WIDTH'(1);
        sum_d   = sum_q + SUM_W'(sample);
        if (sample < min_q) begin
          min_d = sample;
        end
        if (sample > max_q) begin
          max_d = sample;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      min_q   <= '1;
      max_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      min_q   <= min_d;
      max_q   <= max_d;
      drop_q  <= drop_d;
    end
  end

  // Restoring division step. The mean never exceeds the largest sample, so
  // the upper sum bits start below the divisor and only MAG_W quotient bits
  // are produced.
  assign trial = {rem_q, quo_q[MAG_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      rem_q        <= sum_q[SUM_W-1:MAG_W];
      quo_q        <= sum_q[MAG_W-1:0];
      den_q        <= count_q;
      snap_count_q <= count_q;
      snap_min_q   <= min_q;
      snap_max_q   <= max_q;
      snap_drop_q  <= drop_q;
      snap_empty_q <= (count_q == '0);
    end else if (cmd_i.div_step) begin
      if (fits) begin
        rem_q <= COUNT_WIDTH'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[COUNT_WIDTH-1:0];
      end
      quo_q <= {quo_q[MAG_W-2:0], fits};
    end
  end

  // Output register; an empty run reports a zero mean.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sample_count_o   <= snap_count_q;
      min_value_o      <= snap_min_q;
      max_value_o      <= snap_max_q;
      mean_value_o     <= snap_empty_q ? '0 : quo_q;
      empty_run_o      <= snap_empty_q;
      count_overflow_o <= snap_drop_q;
    end
  end

endmodule

FILE: rtl/running_min_max_mean_summary.sv
// Running min/max/mean summary. A non-negative reading is taken and
// folded into the run. A negative reading ends the run: once it is taken
// the input is held off for the steps of the bit-serial mean divider
// (SAMPLE_WIDTH-1 steps) and the load of the output register, and longer
// if the previous summary has not yet been taken. Readings are accepted
// while a finished summary waits at the output. Depends on rmmm_pkg,
// rmmm_ctrl, rmmm_datapath.

module running_min_max_mean_summary
  import rmmm_pkg::*;
#(
  parameter int COUNT_WIDTH  = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: reading
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: sample_count, min_value, max_value, mean_value
  output logic [((COUNT_WIDTH + 3 * (SAMPLE_WIDTH - 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // tuser: empty_run, count_overflow
  output logic [TUSER_W-1:0] m_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready
);

  localparam int MAG_W   = SAMPLE_WIDTH - 1;
  localparam int FIELD_W = COUNT_WIDTH + 3 * MAG_W;
  localparam int OUT_W   = ((FIELD_W + 7) / 8) * 8;

  rmmm_cmd_t              cmd;
  rmmm_stat_t             stat;
  logic [COUNT_WIDTH-1:0] sample_count;
  logic [MAG_W-1:0]       min_value, max_value, mean_value;
  logic                   empty_run, count_overflow;

  rmmm_ctrl #(
    .MAG_W (MAG_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rmmm_datapath #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .reading_i        (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .sample_count_o   (sample_count),
    .min_value_o      (min_value),
    .max_value_o      (max_value),
    .mean_value_o     (mean_value),
    .empty_run_o      (empty_run),
    .count_overflow_o (count_overflow)
  );

  // Pack the result fields, sample_count in the lowest bits and mean_value highest.
  assign m_axis_tdata = OUT_W'({mean_value, max_value, min_value, sample_count});

  always_comb begin
    m_axis_tuser              = '0;
    m_axis_tuser[TUSER_EMPTY] = empty_run;
    m_axis_tuser[TUSER_OVF]   = count_overflow;
  end

endmodule

FILE: rtl/rmmm_checker.sv
// Port-level checks for the running min/max/mean summary block, and the
// bind that attaches them to the top level. Depends on rmmm_pkg and the top level.

module rmmm_checker
  import rmmm_pkg::*;
#(
  parameter int COUNT_WIDTH  = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [((COUNT_WIDTH + 3 * (SAMPLE_WIDTH - 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input logic [TUSER_W-1:0] m_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  localparam int MAG_W = SAMPLE_WIDTH - 1;
  localparam int MIN_L = COUNT_WIDTH;
  localparam int MAX_L = COUNT_WIDTH + MAG_W;
  localparam int AVG_L = COUNT_WIDTH + 2 * MAG_W;

  logic [COUNT_WIDTH-1:0] o_count;
  logic [MAG_W-1:0]       o_min, o_max, o_mean;

  assign o_count = m_axis_tdata[COUNT_WIDTH-1:0];
  assign o_min   = m_axis_tdata[MIN_L+MAG_W-1:MIN_L];
  assign o_max   = m_axis_tdata[MAX_L+MAG_W-1:MAX_L];
  assign o_mean  = m_axis_tdata[AVG_L+MAG_W-1:AVG_L];

  // A stalled summary request stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("summary changed while stalled");

  // An empty run reports zero count, all-ones min, zero max and zero mean.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[TUSER_EMPTY] |->
      o_count == '0 && o_max == '0 && o_mean == '0 && o_min == '1)
    else $error("empty run summary fields wrong");

  // A non-empty run has its mean between its minimum and maximum.
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[TUSER_EMPTY] |->
      o_count != '0 && o_min <= o_mean && o_mean <= o_max)
    else $error("mean outside min/max range");

  // Samples are dropped only once the count is full.
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[TUSER_OVF] |-> o_count == '1)
    else $error("overflow flagged below count limit");

  // An end marker starts the division, so the next cycle takes no request.
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[SAMPLE_WIDTH-1] |=> !s_axis_tready)
    else $error("request taken during mean division");

endmodule

bind running_min_max_mean_summary rmmm_checker #(
  .COUNT_WIDTH  (COUNT_WIDTH),
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rmmm_checker (.*);

FILE: tb/tb_running_min_max_mean_summary.sv
// Self-checking testbench for running_min_max_mean_summary.
// Drives sensor readings over the input stream and scores each summary against a
// predictor. Depends on rmmm_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_running_min_max_mean_summary;
  import rmmm_pkg::*;

  localparam int COUNT_W    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int S_DATA_W   = ((SAMPLE_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((COUNT_W + 3 * (SAMPLE_W - 1) + 7) / 8) * 8;
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRAIN_WAIT = 4 * SAMPLE_W;
  localparam int HOLD_LEN   = 240;
  localparam int RAND_ITEMS = 1300;

  // One expected summary, fields at the widths of the block.
  typedef struct packed {
    logic [15:0] count;
    logic [14:0] lo_val;
    logic [14:0] hi_val;
    logic [14:0] mean_val;
    logic        empty;
    logic        ovf;
  } summary_t;

  // Predicts summaries from accepted readings and scores the block's results.
  class summary_scoreboard;
    logic [15:0] acc_count;
    logic [30:0] acc_sum;
    logic [14:0] acc_lo;
    logic [14:0] acc_hi;
    logic        acc_dropped;
    summary_t    summary_q[$];
    int          errors;
    int          readings;
    int          summaries;
    int          empty_runs;
    int          ovf_runs;

    function void clear_run();
      acc_count   = '0;
      acc_sum     = '0;
      acc_lo      = '1;
      acc_hi      = '0;
      acc_dropped = 1'b0;
    endfunction

    function void note_reading(logic [15:0] reading);
      summary_t    s;
      logic [14:0] mag;
      logic [30:0] quot;
      readings++;
      mag = reading[14:0];
      if (!reading[15]) begin
        // Past the count limit a sample is dropped and only flagged.
        if (acc_count == '1) begin
          acc_dropped = 1'b1;
        end else begin
          acc_count = acc_count + 16'd1;
          acc_sum   = acc_sum + {16'd0, mag};
          if (mag < acc_lo) acc_lo = mag;
          if (mag > acc_hi) acc_hi = mag;
        end
      end else begin
        // End marker: the mean is zero for an empty run, no division.
        quot       = (acc_count == '0) ? '0 : acc_sum / {15'd0, acc_count};
        s.count    = acc_count;
        s.lo_val   = acc_lo;
        s.hi_val   = acc_hi;
        s.mean_val = quot[14:0];
        s.empty    = (acc_count == '0);
        s.ovf      = acc_dropped;
        summary_q.push_back(s);
        clear_run();
      end
    endfunction

    function void field_check(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_summary(logic [M_DATA_W-1:0] tdata, logic [TUSER_W-1:0] tuser);
      summary_t s;
      summaries++;
      if (tuser[TUSER_EMPTY]) empty_runs++;
      if (tuser[TUSER_OVF]) ovf_runs++;
      if (summary_q.size() == 0) begin
        $display("%0t: unexpected summary, expected none, actual tdata %h tuser %b",
                 $time, tdata, tuser);
        errors++;
        return;
      end
      s = summary_q.pop_front();
      field_check("sample_count",   s.count,                tdata[15:0]);
      field_check("min_value",      {1'b0, s.lo_val},       {1'b0, tdata[30:16]});
      field_check("max_value",      {1'b0, s.hi_val},       {1'b0, tdata[45:31]});
      field_check("mean_value",     {1'b0, s.mean_val},     {1'b0, tdata[60:46]});
      field_check("empty_run",      {15'd0, s.empty},       {15'd0, tuser[TUSER_EMPTY]});
      field_check("count_overflow", {15'd0, s.ovf},         {15'd0, tuser[TUSER_OVF]});
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [TUSER_W-1:0]  m_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;

  summary_scoreboard sb;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int cycles   = 0;
  int hold_cycles = 0;

  running_min_max_mean_summary #(
    .COUNT_WIDTH (COUNT_W),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: score every accepted summary, then pick the next ready value.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        sb.check_summary(m_axis_tdata, m_axis_tuser);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        // Long hold-off so that summaries back up and the input stalls.
        hold_left--;
        hold_cycles++;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one reading and hold the request until the block takes it.
  task automatic send_reading(input logic [15:0] reading);
    s_axis_tdata  <= reading;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_reading(reading);
  endtask

  // Random sender gap between requests.
  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 15));
      3:       return 16'($urandom_range(32700, 32767));
      default: return {1'b0, 15'($urandom)};
    endcase
  endfunction

  function automatic logic [15:0] pick_marker();
    case ($urandom_range(0, 7))
      0:       return 16'hFFFF;
      1:       return 16'h8000;
      default: return {1'b1, 15'($urandom)};
    endcase
  endfunction

  // One run: a random number of samples closed by an end marker.
  task automatic random_run(inout int sent);
    int len;
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
    repeat (len) begin
      send_reading(pick_sample());
      idle_gap();
    end
    send_reading(pick_marker());
    idle_gap();
    sent += len + 1;
  endtask

  initial begin
    int sent;
    sb = new();
    sb.clear_run();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty runs, single extremes, truncating mean, back-to-back markers.
    send_reading(16'h8000);
    send_reading(16'd0);
    send_reading(16'hFFFF);
    send_reading(16'h7FFF);
    send_reading(16'h8000);
    send_reading(16'd0);
    send_reading(16'h7FFF);
    send_reading(16'd5);
    send_reading(16'd100);
    send_reading(16'hC000);
    send_reading(16'hFFFF);
    send_reading(16'hFFFF);
    send_reading(16'd1);
    send_reading(16'd2);
    send_reading(16'hAAAA);
    send_reading(16'h5555);
    send_reading(16'h2AAA);
    send_reading(16'h9234);

    // A single-sample run closed by a marker with low bits set.
    send_reading(16'd9);
    send_reading(16'h8001);

    // Random runs, with one long hold-off on the result side part way through.
    sent = 0;
    while (sent < RAND_ITEMS * 3 / 4) begin
      if (sent >= 300 && hold_cycles == 0 && !hold_req) hold_req = 1'b1;
      random_run(sent);
    end

    // Last part without idling on either side.
    quiet = 1'b1;
    while (sent < RAND_ITEMS) random_run(sent);
    s_axis_tvalid <= 1'b0;

    while (sb.summary_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d readings and %0d summaries (%0d empty, %0d with dropped samples).",
             sb.readings, sb.summaries, sb.empty_runs, sb.ovf_runs);
    $display("Result side held off for %0d cycles in one stretch.", hold_cycles);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rmmm_pkg.sv
rtl/rmmm_ctrl.sv
rtl/rmmm_datapath.sv
rtl/running_min_max_mean_summary.sv
rtl/rmmm_checker.sv
tb/tb_running_min_max_mean_summary.sv
